// ===== hdl/vgmcsp_pkg.sv =====
// Shared types and constants for the VGM command stream parser.
package vgmcsp_pkg;

    // Command bytes
    localparam logic [7:0] CMD_FIRST_WR  = 8'hA0;
    localparam logic [7:0] CMD_SECOND_WR = 8'hB4;
    localparam logic [7:0] CMD_DATA_BLK  = 8'h67;
    localparam logic [7:0] CMD_WAIT_N    = 8'h61;
    localparam logic [7:0] CMD_WAIT_735  = 8'h62;
    localparam logic [7:0] CMD_WAIT_882  = 8'h63;
    localparam logic [7:0] CMD_END       = 8'h66;
    localparam logic [3:0] CMD_SHORT_HI  = 4'h7;

    localparam logic [15:0] WAIT_NTSC = 16'd735;
    localparam logic [15:0] WAIT_PAL  = 16'd882;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_EN  = 2'd0;
    localparam logic [1:0] CFG_SECOND_EN = 2'd1;
    localparam logic [1:0] CFG_SPF       = 2'd2;

    localparam int          SPF_W     = 13;
    localparam logic [12:0] SPF_RESET = 13'd735;
    localparam int          BACKLOG_W = 17;
    localparam int          DIV_STEPS = BACKLOG_W;
    localparam int          DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int          OUT_W     = 32;

    typedef enum logic [2:0] {
        KIND_FIRST  = 3'd0,
        KIND_SECOND = 3'd1,
        KIND_FRAMES = 3'd2,
        KIND_END    = 3'd3,
        KIND_UNKNOWN = 3'd4
    } event_kind_t;

    typedef enum logic [2:0] {
        CLS_CHIP_WR = 3'd0,
        CLS_BLOCK   = 3'd1,
        CLS_WAIT_N  = 3'd2,
        CLS_WAIT_FIXED = 3'd3,
        CLS_END     = 3'd4,
        CLS_UNKNOWN = 3'd5
    } cmd_class_t;

    typedef enum logic [1:0] {
        WAIT_SEL_735   = 2'd0,
        WAIT_SEL_882   = 2'd1,
        WAIT_SEL_SHORT = 2'd2,
        WAIT_SEL_LONG  = 2'd3
    } wait_sel_t;

    typedef enum logic [1:0] {
        RES_CHIP    = 2'd0,
        RES_FRAMES  = 2'd1,
        RES_END     = 2'd2,
        RES_UNKNOWN = 2'd3
    } res_sel_t;

    // Controller -> datapath
    typedef struct packed {
        logic      cap_cmd;
        logic      cap_addr;
        logic      cap_wlo;
        logic      len_we;
        logic [1:0] len_lane;
        logic      skip_dec;
        logic      add_wait;
        wait_sel_t wait_sel;
        logic      div_init;
        logic      div_step;
        logic      res_load;
        res_sel_t  res_sel;
        logic      out_push;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        cmd_class_t byte_class;
        logic       report_write;
        logic       len_nonzero;
        logic       skip_is_one;
        logic       backlog_ge;
        logic       div_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== hdl/vgm_command_stream_parser_unit.sv =====
// Top level of the VGM command stream parser.
//
// Usage: feed the command bytes of a VGM log, one byte per word, on the
// s_* channel. Chip register writes (0xA0 / 0xB4, when enabled), frame
// ticks from the wait commands, end of stream (0x66) and unknown commands
// come out as one word each on the m_* channel.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 first chip enable, 1 second chip enable, 2 samples per frame).
// Write it only while the parser is idle.
// Throughput: bytes that give no word are taken one per cycle, back to back,
// while the parser is in its run state; the last byte of a wait is the
// exception. A reported chip write is loaded into the result register with
// its data byte and goes to the output register from the emit state. After
// the last wait byte the parser compares the backlog with one frame; at or
// above it, the frame divider (restoring, one quotient bit per cycle over 17
// bits) runs and the emit state loads its word into the output register.
// Stalls: the output register holds one word; the parser keeps taking
// bytes while it waits and only stops when a second word is ready.
// After end or unknown command every byte is taken and dropped until reset.
// Reset: asynchronous, active low; restores the register defaults and
// clears the parse phase and the sample backlog.
module vgm_command_stream_parser_unit
    import vgmcsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] data_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,    // [2:0] event_kind, [10:3] reg_addr,
                                         // [18:11] reg_data, [26:19] frame_count
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [SPF_W-1:0] cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    vgmcsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    vgmcsp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

endmodule

// ===== hdl/vgmcsp_ctrl.sv =====
// Controller: parse phase and block sequencing for the command stream parser.
module vgmcsp_ctrl
    import vgmcsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [11:0] {
        PH_CMD      = 12'b0000_0000_0001,
        PH_ADDR     = 12'b0000_0000_0010,
        PH_DATA     = 12'b0000_0000_0100,
        PH_WAIT_LO  = 12'b0000_0000_1000,
        PH_WAIT_HI  = 12'b0000_0001_0000,
        PH_BLK_TAG  = 12'b0000_0010_0000,
        PH_BLK_TYPE = 12'b0000_0100_0000,
        PH_LEN0     = 12'b0000_1000_0000,
        PH_LEN1     = 12'b0001_0000_0000,
        PH_LEN2     = 12'b0010_0000_0000,
        PH_LEN3     = 12'b0100_0000_0000,
        PH_SKIP     = 12'b1000_0000_0000
    } phase_t;

    typedef enum logic [4:0] {
        ST_RUN  = 5'b00001,
        ST_CMP  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_HALT = 5'b10000
    } state_t;

    phase_t phase_reg, phase_next;
    state_t state_reg, state_next;
    logic   halt_pend_reg, halt_pend_next;
    logic   accept;

    assign s_tready = (state_reg == ST_RUN) || (state_reg == ST_HALT);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next     = phase_reg;
        state_next     = state_reg;
        halt_pend_next = halt_pend_reg;
        cmd            = '0;
        cmd.wait_sel   = WAIT_SEL_LONG;
        cmd.res_sel    = RES_CHIP;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        PH_CMD:
                        begin
                            cmd.cap_cmd = 1'b1;
                            case (stat.byte_class)
                                CLS_CHIP_WR: phase_next = PH_ADDR;
                                CLS_BLOCK:   phase_next = PH_BLK_TAG;
                                CLS_WAIT_N:  phase_next = PH_WAIT_LO;
                                CLS_WAIT_FIXED:
                                begin
                                    // datapath picks the amount from the byte itself
                                    cmd.add_wait = 1'b1;
                                    cmd.wait_sel = WAIT_SEL_SHORT;
                                    state_next   = ST_CMP;
                                end
                                CLS_END:
                                begin
                                    cmd.res_load   = 1'b1;
                                    cmd.res_sel    = RES_END;
                                    halt_pend_next = 1'b1;
                                    state_next     = ST_EMIT;
                                end
                                default:
                                begin
                                    cmd.res_load   = 1'b1;
                                    cmd.res_sel    = RES_UNKNOWN;
                                    halt_pend_next = 1'b1;
                                    state_next     = ST_EMIT;
                                end
                            endcase
                        end
                        PH_ADDR:
                        begin
                            cmd.cap_addr = 1'b1;
                            phase_next   = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            phase_next = PH_CMD;
                            if (stat.report_write)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.res_sel  = RES_CHIP;
                                state_next   = ST_EMIT;
                            end
                        end
                        PH_WAIT_LO:
                        begin
                            cmd.cap_wlo = 1'b1;
                            phase_next  = PH_WAIT_HI;
                        end
                        PH_WAIT_HI:
                        begin
                            cmd.add_wait = 1'b1;
                            cmd.wait_sel = WAIT_SEL_LONG;
                            phase_next   = PH_CMD;
                            state_next   = ST_CMP;
                        end
                        PH_BLK_TAG:  phase_next = PH_BLK_TYPE;
                        PH_BLK_TYPE: phase_next = PH_LEN0;
                        PH_LEN0:
                        begin
                            cmd.len_we   = 1'b1;
                            cmd.len_lane = 2'd0;
                            phase_next   = PH_LEN1;
                        end
                        PH_LEN1:
                        begin
                            cmd.len_we   = 1'b1;
                            cmd.len_lane = 2'd1;
                            phase_next   = PH_LEN2;
                        end
                        PH_LEN2:
                        begin
                            cmd.len_we   = 1'b1;
                            cmd.len_lane = 2'd2;
                            phase_next   = PH_LEN3;
                        end
                        PH_LEN3:
                        begin
                            cmd.len_we   = 1'b1;
                            cmd.len_lane = 2'd3;
                            phase_next   = stat.len_nonzero ? PH_SKIP : PH_CMD;
                        end
                        PH_SKIP:
                        begin
                            cmd.skip_dec = 1'b1;
                            if (stat.skip_is_one)
                                phase_next = PH_CMD;
                        end
                        default: phase_next = PH_CMD;
                    endcase
                end
            end
            ST_CMP:
            begin
                if (stat.backlog_ge)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                    state_next = ST_RUN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FRAMES;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = halt_pend_reg ? ST_HALT : ST_RUN;
                end
            end
            ST_HALT: state_next = ST_HALT;
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            state_reg     <= ST_RUN;
            halt_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            state_reg     <= state_next;
            halt_pend_reg <= halt_pend_next;
        end
    end

endmodule

// ===== hdl/vgmcsp_datapath.sv =====
// Datapath: operand registers, sample backlog, frame divider and output register.
module vgmcsp_datapath
    import vgmcsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [SPF_W-1:0] cfg_data,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat
);

    logic                 first_en_reg, second_en_reg;
    logic [SPF_W-1:0]     spf_reg;
    logic [SPF_W-1:0]     spf_eff;

    logic [7:0]           cmd_reg, addr_reg, wlo_reg;
    logic [31:0]          skip_reg;
    logic [BACKLOG_W-1:0] backlog_reg, backlog_next;

    logic [SPF_W-1:0]     rem_reg;
    logic [BACKLOG_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SPF_W:0]       trial;
    logic                 trial_ge;
    logic [SPF_W-1:0]     rem_step;
    logic [BACKLOG_W-1:0] quo_step;
    logic [7:0]           frames_sat;

    logic [15:0]          wait_amt;
    cmd_class_t           byte_class;
    event_kind_t          res_kind_reg;
    logic [7:0]           res_addr_reg, res_data_reg, res_frames_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg;

    assign spf_eff = (spf_reg == '0) ? SPF_W'(1) : spf_reg;

    // Byte classification at the command phase
    always_comb
    begin
        if (s_tdata == CMD_FIRST_WR || s_tdata == CMD_SECOND_WR)
            byte_class = CLS_CHIP_WR;
        else if (s_tdata == CMD_DATA_BLK)
            byte_class = CLS_BLOCK;
        else if (s_tdata == CMD_WAIT_N)
            byte_class = CLS_WAIT_N;
        else if (s_tdata == CMD_WAIT_735 || s_tdata == CMD_WAIT_882
                 || s_tdata[7:4] == CMD_SHORT_HI)
            byte_class = CLS_WAIT_FIXED;
        else if (s_tdata == CMD_END)
            byte_class = CLS_END;
        else
            byte_class = CLS_UNKNOWN;
    end

    assign stat.byte_class   = byte_class;
    assign stat.report_write = (cmd_reg == CMD_FIRST_WR && first_en_reg)
                            || (cmd_reg == CMD_SECOND_WR && second_en_reg);
    assign stat.len_nonzero  = |{s_tdata, skip_reg[23:0]};
    assign stat.skip_is_one  = (skip_reg == 32'd1);
    assign stat.backlog_ge   = (backlog_reg >= {{(BACKLOG_W-SPF_W){1'b0}}, spf_eff});
    assign stat.div_last     = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.out_free     = !out_valid_reg || m_tready;

    // Wait amount; the short-wait select also covers the two fixed waits
    always_comb
    begin
        case (cmd.wait_sel)
            WAIT_SEL_SHORT:
            begin
                if (s_tdata == CMD_WAIT_735)
                    wait_amt = WAIT_NTSC;
                else if (s_tdata == CMD_WAIT_882)
                    wait_amt = WAIT_PAL;
                else
                    wait_amt = {12'd0, s_tdata[3:0]} + 16'd1;
            end
            WAIT_SEL_735:  wait_amt = WAIT_NTSC;
            WAIT_SEL_882:  wait_amt = WAIT_PAL;
            WAIT_SEL_LONG: wait_amt = {s_tdata, wlo_reg};
            default:       wait_amt = {s_tdata, wlo_reg};
        endcase
    end

    // One restoring division step
    assign trial    = {rem_reg, quo_reg[BACKLOG_W-1]};
    assign trial_ge = (trial >= {1'b0, spf_eff});
    assign rem_step = trial_ge ? SPF_W'(trial - {1'b0, spf_eff}) : trial[SPF_W-1:0];
    assign quo_step = {quo_reg[BACKLOG_W-2:0], trial_ge};
    assign frames_sat = (|quo_step[BACKLOG_W-1:8]) ? 8'hFF : quo_step[7:0];

    always_comb
    begin
        backlog_next = backlog_reg;
        if (cmd.add_wait)
            backlog_next = backlog_reg + {1'b0, wait_amt};
        else if (cmd.div_step && stat.div_last)
            backlog_next = {{(BACKLOG_W-SPF_W){1'b0}}, rem_step};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_push)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_en_reg  <= 1'b1;
            second_en_reg <= 1'b0;
            spf_reg       <= SPF_RESET;
            backlog_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_EN:  first_en_reg  <= cfg_data[0];
                    CFG_SECOND_EN: second_en_reg <= cfg_data[0];
                    CFG_SPF:       spf_reg       <= cfg_data;
                    default:       ;
                endcase
            end
            backlog_reg   <= backlog_next;
            if (cmd.div_init)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_cmd)
            cmd_reg <= s_tdata;
        if (cmd.cap_addr)
            addr_reg <= s_tdata;
        if (cmd.cap_wlo)
            wlo_reg <= s_tdata;

        if (cmd.len_we)
        begin
            case (cmd.len_lane)
                2'd0:    skip_reg        <= {24'd0, s_tdata};
                2'd1:    skip_reg[15:8]  <= s_tdata;
                2'd2:    skip_reg[23:16] <= s_tdata;
                default: skip_reg[31:24] <= s_tdata;
            endcase
        end
        else if (cmd.skip_dec)
            skip_reg <= skip_reg - 32'd1;

        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= backlog_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end

        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_CHIP:
                begin
                    res_kind_reg   <= (cmd_reg == CMD_FIRST_WR) ? KIND_FIRST : KIND_SECOND;
                    res_addr_reg   <= addr_reg;
                    res_data_reg   <= s_tdata;
                    res_frames_reg <= 8'd0;
                end
                RES_FRAMES:
                begin
                    res_kind_reg   <= KIND_FRAMES;
                    res_addr_reg   <= 8'd0;
                    res_data_reg   <= 8'd0;
                    res_frames_reg <= frames_sat;
                end
                RES_END:
                begin
                    res_kind_reg   <= KIND_END;
                    res_addr_reg   <= 8'd0;
                    res_data_reg   <= 8'd0;
                    res_frames_reg <= 8'd0;
                end
                default:
                begin
                    res_kind_reg   <= KIND_UNKNOWN;
                    res_addr_reg   <= 8'd0;
                    res_data_reg   <= 8'd0;
                    res_frames_reg <= 8'd0;
                end
            endcase
        end

        if (cmd.out_push)
            out_data_reg <= {5'd0, res_frames_reg, res_data_reg, res_addr_reg, res_kind_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
